// File: sv/gipm_pkg.sv
package gipm_pkg;

  localparam int MAX_WINDOW    = 15;
  localparam int MAX_INTERVALS = 16;
  localparam int DEPTH         = MAX_WINDOW + 1;

  localparam int PITCH_W  = 7;
  localparam int DIFF_W   = PITCH_W + 1;
  localparam int IVL_W    = 8;
  localparam int WIN_W    = 4;
  localparam int LEN_W    = 5;
  localparam int WORD_W   = 64;
  localparam int CFG_IDX_W = 3;
  localparam int IVL_PER_WORD = WORD_W / IVL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAP_WINDOW     = 3'd0,
    REG_PATTERN_LENGTH = 3'd1,
    REG_INTERVALS_LO   = 3'd2,
    REG_INTERVALS_HI   = 3'd3,
    REG_INVERT_VERDICT = 3'd4
  } cfg_reg_t;

  // One remembered note: pitch, occupancy and partial-match bits
  typedef struct packed {
    logic [PITCH_W-1:0]       pitch;
    logic                     valid;
    logic [MAX_INTERVALS-1:0] prog;
  } gipm_entry_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic shift;   // advance the row by one note
    logic clear;   // drop the entry handed in (new run starts)
    logic enable;  // cell lies inside the gap window
  } gipm_ctl_t;

  typedef logic [MAX_INTERVALS-1:0][IVL_W-1:0] ivl_array_t;

  // Result word bit positions
  typedef struct packed {
    logic verdict;
    logic found;
    logic match_end;
  } gipm_result_t;

endpackage

// File: sv/gipm_cell.sv
module gipm_cell
  import gipm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  gipm_ctl_t                ctl,
  input  logic [PITCH_W-1:0]       note,
  input  ivl_array_t               ivl,
  input  logic [MAX_INTERVALS-1:0] len_mask,
  input  gipm_entry_t              up,
  output gipm_entry_t              ent,
  output logic [MAX_INTERVALS-1:0] hit
);

  logic [DIFF_W-1:0] diff;

  assign diff = {1'b0, note} - {1'b0, ent.pitch};

  // Bit k: a chain of k intervals ending here extends to the new note
  always_comb begin
    for (int k = 0; k < MAX_INTERVALS; k++) begin
      hit[k] = ctl.enable & ent.valid & ent.prog[k] & len_mask[k] &
               (diff == ivl[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.pitch <= '0;
      ent.valid <= 1'b0;
      ent.prog  <= '0;
    end else if (ctl.shift) begin
      ent.pitch <= up.pitch;
      ent.valid <= up.valid & ~ctl.clear;
      ent.prog  <= ctl.clear ? '0 : up.prog;
    end
  end

endmodule

// File: sv/gipm_obuf.sv
module gipm_obuf
  import gipm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  gipm_result_t push_data,
  output logic         space,
  output logic         out_valid,
  input  logic         out_ready,
  output gipm_result_t out_data
);

  logic         skid_valid;
  gipm_result_t skid_data;
  logic         take;

  assign take  = out_valid & out_ready;
  assign space = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

// File: sv/gapped_interval_pattern_match.sv
// Gapped interval pattern matcher.
// Input channel s_*: one word per note-start event; tdata holds the pitch,
// tuser flags the first note of a new file (clears history and found flag).
// Output channel m_*: one word per accepted note with match_end, the sticky
// found flag and verdict (found xor invert_verdict).
// Configuration channel cfg_*: register index plus 64-bit data, always ready;
// write only while no note is in flight.
// A row of DEPTH cells holds the most recent notes with their partial-match
// bits. Every cell compares the incoming note with its own note in parallel
// and the row shifts by one on each accepted word, so one note is taken
// every cycle while s_tready is high; each result is registered.
// A two-entry output buffer (output register plus skid) lets a new note in
// while a finished result waits; s_tready drops only when both are full,
// i.e. after the receiver has stalled for two words.
// Reset clears the cells, the found flag, the output buffer and loads the
// registers with window 0, pattern length 1, all intervals 0, no inversion.
module gapped_interval_pattern_match
  import gipm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [6:0] note_pitch, [7] zero
  input  logic              s_tuser,   // [0] first_note
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [0] match_end, [1] found, [2] verdict, [7:3] zero
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0] cfg_data
);

  // Configuration registers
  logic [WIN_W-1:0]  gap_window;
  logic [LEN_W-1:0]  pattern_length;
  logic [WORD_W-1:0] intervals_lo;
  logic [WORD_W-1:0] intervals_hi;
  logic              invert_verdict;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_window     <= '0;
      pattern_length <= LEN_W'(1);
      intervals_lo   <= '0;
      intervals_hi   <= '0;
      invert_verdict <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAP_WINDOW:     gap_window     <= cfg_data[WIN_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_INTERVALS_LO:   intervals_lo   <= cfg_data;
        REG_INTERVALS_HI:   intervals_hi   <= cfg_data;
        REG_INVERT_VERDICT: invert_verdict <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturate window and length
  logic [WIN_W-1:0] win_sat;
  logic [LEN_W-1:0] len_sat;

  assign win_sat = (gap_window > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : gap_window;
  assign len_sat = (pattern_length > LEN_W'(MAX_INTERVALS)) ?
                   LEN_W'(MAX_INTERVALS) : pattern_length;

  // Interval bytes unpacked low first; masks for the active pattern steps
  ivl_array_t               ivl;
  logic [MAX_INTERVALS-1:0] len_mask;   // step k lies inside the pattern
  logic [MAX_INTERVALS-1:0] last_mask;  // step k completes the pattern

  always_comb begin
    for (int k = 0; k < MAX_INTERVALS; k++) begin
      if (k < IVL_PER_WORD) begin
        ivl[k] = intervals_lo[(k % IVL_PER_WORD)*IVL_W +: IVL_W];
      end else if (k < 2*IVL_PER_WORD) begin
        ivl[k] = intervals_hi[(k % IVL_PER_WORD)*IVL_W +: IVL_W];
      end else begin
        ivl[k] = '0;
      end
      len_mask[k]  = (k < int'(len_sat));
      last_mask[k] = ((k + 1) == int'(len_sat));
    end
  end

  // Input word
  logic               accept;
  logic [PITCH_W-1:0] note;
  logic               first;

  assign accept = s_tvalid & s_tready;
  assign note   = s_tdata[PITCH_W-1:0];
  assign first  = s_tuser;

  // Row of cells; cell 0 takes the new note
  gipm_entry_t              ent [DEPTH];
  gipm_entry_t              up  [DEPTH];
  gipm_ctl_t                ctl [DEPTH];
  logic [MAX_INTERVALS-1:0] hit [DEPTH];
  gipm_entry_t              new_ent;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctl[i].shift  = accept;
    // the new note itself stays valid; older entries drop on a first note
    assign ctl[i].clear  = (i == 0) ? 1'b0 : first;
    assign ctl[i].enable = (i <= int'(win_sat)) & ~first;
    assign up[i]         = (i == 0) ? new_ent : ent[(i == 0) ? 0 : i-1];

    gipm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl[i]),
      .note     (note),
      .ivl      (ivl),
      .len_mask (len_mask),
      .up       (up[i]),
      .ent      (ent[i]),
      .hit      (hit[i])
    );
  end

  // Merge the hits of all cells
  logic [MAX_INTERVALS-1:0] adv;
  logic                     match;
  logic [MAX_INTERVALS-1:0] prog_new;

  always_comb begin
    adv = '0;
    for (int i = 0; i < DEPTH; i++) begin
      adv = adv | hit[i];
    end
  end

  // Empty pattern matches at every note and starts no chain
  assign match    = (len_sat == '0) | (|(adv & last_mask));
  assign prog_new = (len_sat == '0) ? '0 :
                    ({adv[MAX_INTERVALS-2:0] & ~last_mask[MAX_INTERVALS-2:0], 1'b0} |
                     MAX_INTERVALS'(1));

  assign new_ent.pitch = note;
  assign new_ent.valid = 1'b1;
  assign new_ent.prog  = prog_new;

  // Sticky found flag
  logic         found;
  logic         found_next;
  gipm_result_t res;
  gipm_result_t out_res;

  assign found_next = (found & ~first) | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= found_next;
    end
  end

  assign res.match_end = match;
  assign res.found     = found_next;
  assign res.verdict   = found_next ^ invert_verdict;

  // Output register with skid
  gipm_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .space     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {5'b0, out_res};

endmodule

// File: tb/tb.sv
module tb;
  import gipm_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;   // [6:0] note_pitch, [7] zero
  logic                 s_tuser;   // [0] first_note
  logic                 m_tvalid;
  logic                 m_tready;
  logic [7:0]           m_tdata;   // [0] match_end, [1] found, [2] verdict, [7:3] zero
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  // Steady stretches: while set, the sender never idles and the receiver skips random stalls
  bit tx_steady;
  bit rx_steady;
  int notes_sent;

  // Tracks the note history and found flag the way the matcher should, and
  // holds one expected result word per accepted note.
  class melody_scoreboard;
    logic [WIN_W-1:0]         gap_window;
    logic [LEN_W-1:0]         pattern_length;
    ivl_array_t               intervals;
    logic                     invert;
    logic [PITCH_W-1:0]       hist_pitch [DEPTH];
    logic                     hist_valid [DEPTH];
    logic [MAX_INTERVALS-1:0] hist_prog  [DEPTH];
    logic                     found;
    gipm_result_t             pending_verdicts [$];
    int                       fail_count;

    function new();
      gap_window     = '0;
      pattern_length = LEN_W'(1);
      intervals      = '0;
      invert         = 1'b0;
      fail_count     = 0;
      clear_history();
    endfunction

    function void clear_history();
      foreach (hist_pitch[i]) begin
        hist_pitch[i] = '0;
        hist_valid[i] = 1'b0;
        hist_prog[i]  = '0;
      end
      found = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        REG_GAP_WINDOW:     gap_window = data[WIN_W-1:0];
        REG_PATTERN_LENGTH: pattern_length = data[LEN_W-1:0];
        REG_INTERVALS_LO:   intervals[IVL_PER_WORD-1:0] = data;
        REG_INTERVALS_HI:   intervals[MAX_INTERVALS-1:IVL_PER_WORD] = data;
        REG_INVERT_VERDICT: invert = data[0];
        default: ;
      endcase
    endfunction

    // Compare the new note against every remembered note inside the window,
    // extend each partial chain whose next interval fits, then shift it in.
    function void take_note(logic [PITCH_W-1:0] pitch, logic first_note);
      int                       win;
      int                       len;
      int                       diff;
      logic [MAX_INTERVALS-1:0] prog;
      logic                     hit;
      gipm_result_t             want;
      if (first_note) clear_history();
      win  = gap_window;
      len  = (pattern_length > MAX_INTERVALS) ? MAX_INTERVALS : pattern_length;
      prog = '0;
      hit  = 1'b0;
      if (len == 0) begin
        hit = 1'b1;  // empty pattern completes at every note
      end else begin
        prog[0] = 1'b1;
        for (int d = 0; d <= win && d < DEPTH; d++) begin
          if (!hist_valid[d]) continue;
          diff = int'(pitch) - int'(hist_pitch[d]);
          for (int k = 0; k < len; k++) begin
            if (!hist_prog[d][k] || diff != int'($signed(intervals[k]))) continue;
            if (k + 1 == len) hit = 1'b1;
            else prog[k+1] = 1'b1;
          end
        end
      end
      for (int i = DEPTH - 1; i > 0; i--) begin
        hist_pitch[i] = hist_pitch[i-1];
        hist_valid[i] = hist_valid[i-1];
        hist_prog[i]  = hist_prog[i-1];
      end
      hist_pitch[0] = pitch;
      hist_valid[0] = 1'b1;
      hist_prog[0]  = prog;
      found = found | hit;
      want.match_end = hit;
      want.found     = found;
      want.verdict   = found ^ invert;
      pending_verdicts.push_back(want);
    endfunction

    function void check_verdict(logic [7:0] word);
      gipm_result_t want;
      gipm_result_t got;
      if (pending_verdicts.size() == 0) begin
        $error("result word %h with no note pending", word);
        fail_count++;
        return;
      end
      want = pending_verdicts.pop_front();
      got  = word[2:0];
      if (got.match_end !== want.match_end) begin
        $error("match_end: expected %0d, got %0d", want.match_end, got.match_end);
        fail_count++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        fail_count++;
      end
      if (got.verdict !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
        fail_count++;
      end
      if (word[7:3] !== 5'd0) begin
        $error("tdata pad: expected 0, got %h", word[7:3]);
        fail_count++;
      end
    endfunction
  endclass

  melody_scoreboard sb;

  gapped_interval_pattern_match dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Sample both channels at the rising edge; check the outgoing word first,
  // since it belongs to a note taken at an earlier edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
      if (s_tvalid && s_tready) sb.take_note(s_tdata[PITCH_W-1:0], s_tuser);
    end
  end

  // Idle length: mostly short, now and then a long one
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 85) return $urandom_range(2, 4);
    if (r < 96) return $urandom_range(5, 10);
    return $urandom_range(20, 40);
  endfunction

  // Interval byte: mostly small steps, sometimes -128 (never matches),
  // sometimes any byte at all
  function automatic logic [63:0] pick_intervals();
    logic [63:0] w;
    int          r;
    for (int b = 0; b < IVL_PER_WORD; b++) begin
      r = $urandom_range(0, 99);
      if (r < 85) w[b*IVL_W +: IVL_W] = IVL_W'($urandom_range(0, 24) - 12);
      else if (r < 90) w[b*IVL_W +: IVL_W] = 8'h80;
      else w[b*IVL_W +: IVL_W] = IVL_W'($urandom);
    end
    return w;
  endfunction

  // Offer one note; called at a falling edge, returns at the falling edge
  // after the word was taken
  task automatic send_note(input logic [PITCH_W-1:0] pitch, input logic first_note);
    int gap;
    gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : idle_span();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, pitch};
    s_tuser  <= first_note;
    do @(posedge clk); while (!s_tready);
    notes_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Rewrite every register; narrow registers sometimes carry junk above their
  // width, and now and then an unused index gets a write as well
  task automatic retune(input int win, input int len, input logic [63:0] lo,
                        input logic [63:0] hi, input logic inv);
    logic [63:0] junk;
    junk = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom} : 64'd0;
    write_cfg(REG_GAP_WINDOW, (junk << WIN_W) | 64'(win));
    write_cfg(REG_PATTERN_LENGTH, (junk << LEN_W) | 64'(len));
    write_cfg(REG_INTERVALS_LO, lo);
    write_cfg(REG_INTERVALS_HI, hi);
    write_cfg(REG_INVERT_VERDICT, (junk << 1) | 64'(inv));
    if ($urandom_range(0, 3) == 0)
      write_cfg(CFG_IDX_W'($urandom_range(int'(REG_INVERT_VERDICT) + 1, 7)),
                {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Drop the input valid and wait until every expected word is back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Receiver: random stalls, steady stretches, and a periodic long hold-off
  // so the output buffer fills and s_tready drops
  initial begin
    int   hold_left;
    int   cycle_n;
    logic next_ready;
    hold_left = 0;
    cycle_n   = 0;
    forever begin
      @(negedge clk);
      cycle_n++;
      if (cycle_n % 500 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      next_ready = 1'b1;
      if (hold_left > 0) begin
        next_ready = 1'b0;
        hold_left--;
      end else if (cycle_n % 700 == 300) begin
        hold_left  = $urandom_range(40, 60);
        next_ready = 1'b0;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        hold_left  = idle_span() - 1;
        next_ready = 1'b0;
      end
      m_tready <= next_ready;
    end
  end

  initial begin
    ivl_array_t  ivls;
    logic [63:0] lo;
    logic [63:0] hi;
    int          win;
    int          len;
    int          len_eff;
    int          budget;
    int          fill;
    int          p;

    sb         = new();
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    m_tready   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    notes_sent = 0;
    tx_steady  = 1'b1;
    rx_steady  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset registers: one zero interval, no gap - repeated pitches match.
    // Pitch extremes and a first note that clears the found flag.
    send_note(7'd0, 1'b1);
    send_note(7'd0, 1'b0);
    send_note(7'd127, 1'b0);
    send_note(7'd127, 1'b0);
    send_note(7'd64, 1'b1);
    send_note(7'd64, 1'b0);
    settle();

    // Widest steps +127 then -127, full window, verdict inverted
    retune(MAX_WINDOW, 2, 64'h817F, 64'h0, 1'b1);
    send_note(7'd0, 1'b1);
    send_note(7'd127, 1'b0);
    send_note(7'd0, 1'b0);
    send_note(7'd50, 1'b0);
    settle();

    // Empty pattern matches on every note
    retune(MAX_WINDOW, 0, 64'h817F, 64'h0, 1'b0);
    send_note(7'd3, 1'b0);
    send_note(7'd100, 1'b1);
    settle();

    // Interval of -128 never fits a pitch difference
    retune(0, 1, 64'h80, 64'h0, 1'b0);
    send_note(7'd10, 1'b1);
    send_note(7'd10, 1'b0);
    send_note(7'd127, 1'b0);
    send_note(7'd0, 1'b0);
    settle();

    // Random phases: mostly chains that follow the pattern with random
    // fillers in the gaps, some chains broken by too long a gap or a
    // detuned note, the rest plain noise
    for (int ph = 0; ph < 12; ph++) begin
      win = (ph == 0) ? 0 : (ph == 1) ? MAX_WINDOW : $urandom_range(0, MAX_WINDOW);
      if (ph == 2) len = 0;
      else if (ph == 3) len = MAX_INTERVALS;
      else if (ph == 4) len = $urandom_range(MAX_INTERVALS + 1, 31);
      else if ($urandom_range(0, 4) == 0) len = $urandom_range(7, MAX_INTERVALS);
      else len = $urandom_range(1, 6);
      lo = pick_intervals();
      hi = pick_intervals();
      retune(win, len, lo, hi, 1'(ph % 2));
      tx_steady = ($urandom_range(0, 3) == 0);
      ivls      = {hi, lo};
      len_eff   = (len > MAX_INTERVALS) ? MAX_INTERVALS : len;
      budget    = notes_sent + 120;
      while (notes_sent < budget) begin
        if (len_eff > 0 && $urandom_range(0, 9) < 7) begin
          p = $urandom_range(0, 127);
          send_note(7'(p), $urandom_range(0, 7) == 0);
          for (int k = 0; k < len_eff; k++) begin
            fill = ($urandom_range(0, 9) == 0) ? win + 1 : $urandom_range(0, win);
            repeat (fill) send_note(7'($urandom), 1'b0);
            p = p + int'($signed(ivls[k]));
            if ($urandom_range(0, 19) == 0) p = p + 1;
            p = p & 127;  // wrap off-range pitches; breaks the chain
            send_note(7'(p), 1'b0);
          end
        end else begin
          repeat ($urandom_range(1, 8)) send_note(7'($urandom), $urandom_range(0, 15) == 0);
        end
      end
      settle();
    end

    repeat (10) @(negedge clk);
    if (sb.fail_count == 0 && sb.pending_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hold a hard limit well past the slowest legal run
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
